@@ rtl/rsdsd_pkg.sv @@
`timescale 1ns / 1ps
// Package for the rotor spin direction and speed detector.
// Holds register indexes, mode and decision codes, zone codes and angle limits.
// No dependencies.
package rsdsd_pkg;

    localparam int unsigned CFG_AW = 2;
    localparam int unsigned CFG_DW = 32;

    localparam logic [CFG_AW-1:0] REG_SPEED_BASE = 2'd0;
    localparam logic [CFG_AW-1:0] REG_INTERVAL_LIMIT = 2'd1;
    localparam logic [CFG_AW-1:0] REG_MIN_START_SPEED = 2'd2;

    localparam logic [14:0] INTERVAL_LIMIT_RESET = 15'd1000;

    localparam logic [1:0] MODE_ANGLE = 2'd0;
    localparam logic [1:0] MODE_TICK = 2'd1;
    localparam logic [1:0] MODE_RESTART = 2'd2;

    localparam logic [1:0] DEC_NONE = 2'd0;
    localparam logic [1:0] DEC_STANDSTILL = 2'd1;
    localparam logic [1:0] DEC_BRAKE = 2'd2;
    localparam logic [1:0] DEC_FORWARD = 2'd3;

    localparam logic [1:0] DIR_UNKNOWN = 2'd0;
    localparam logic [1:0] DIR_CW = 2'd1;
    localparam logic [1:0] DIR_CCW = 2'd2;

    localparam logic [1:0] ZONE_NONE = 2'd0;
    localparam logic [1:0] ZONE_LOW = 2'd1;
    localparam logic [1:0] ZONE_MID = 2'd2;
    localparam logic [1:0] ZONE_HIGH = 2'd3;

    localparam logic [15:0] THETA_LOW_LIM = 16'd1820;
    localparam logic [15:0] THETA_MID_LO = 16'd30947;
    localparam logic [15:0] THETA_MID_HI = 16'd34588;
    localparam logic [15:0] THETA_HIGH_LIM = 16'd63714;

    localparam logic [7:0] SHAKE_LIMIT = 8'd4;
    localparam logic [7:0] STORE_BRAKE_MIN = 8'd3;
    localparam logic [7:0] STORE_FWD_MIN = 8'd2;

endpackage

@@ rtl/rsdsd_in_if.sv @@
`timescale 1ns / 1ps
// Request channel of the rotor spin detector: one angle sample, tick or restart.
// Depends on nothing.
interface rsdsd_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [15:0] theta;

    modport source (output valid, output mode, output theta, input ready);
    modport sink (input valid, input mode, input theta, output ready);
endinterface

@@ rtl/rsdsd_res_if.sv @@
`timescale 1ns / 1ps
// Result channel of the rotor spin detector: decision, speed, direction, overflow.
// Depends on nothing.
interface rsdsd_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  decision;
    logic [31:0] speed;
    logic [1:0]  direction;
    logic        overflow;

    modport source (output valid, output decision, output speed, output direction,
                    output overflow, input ready);
    modport sink (input valid, input decision, input speed, input direction,
                  input overflow, output ready);
endinterface

@@ rtl/rsdsd_div.sv @@
`timescale 1ns / 1ps
// Restoring serial divider, 32-bit dividend by 16-bit divisor, one quotient bit a cycle.
// Depends on nothing.
module rsdsd_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [15:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_quotient
);

    logic        r_busy, n_busy;
    logic [4:0]  r_cnt, n_cnt;
    logic [15:0] r_rem, n_rem;
    logic [31:0] r_quo, n_quo;
    logic [15:0] r_dvs, n_dvs;

    logic [16:0] w_shift;
    logic        w_ge;
    logic [16:0] w_diff;

    // Shift in the next dividend bit and try one subtraction.
    assign w_shift = {r_rem, r_quo[31]};
    assign w_ge = w_shift >= {1'b0, r_dvs};
    assign w_diff = w_shift - {1'b0, r_dvs};

    assign o_done = r_busy && (r_cnt == 5'd31);
    assign o_quotient = {r_quo[30:0], w_ge};

    always_comb begin
        n_busy = r_busy;
        n_cnt = r_cnt;
        n_rem = r_rem;
        n_quo = r_quo;
        n_dvs = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt = 5'd0;
            n_rem = 16'd0;
            n_quo = i_dividend;
            n_dvs = i_divisor;
        end else if (r_busy) begin
            n_rem = w_ge ? w_diff[15:0] : w_shift[15:0];
            n_quo = {r_quo[30:0], w_ge};
            n_cnt = r_cnt + 5'd1;
            if (r_cnt == 5'd31) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt <= 5'd0;
        end else begin
            r_busy <= n_busy;
            r_cnt <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

endmodule

@@ rtl/rotor_spin_direction_speed_detect.sv @@
`timescale 1ns / 1ps
// Rotor spin direction and speed detector: top level with sequencer and state.
// Depends on rsdsd_pkg, rsdsd_in_if, rsdsd_res_if and rsdsd_div.

// Each request is an electrical angle sample, a timer tick or a restart, and each
// request produces exactly one result carrying the start decision, the latest
// measured speed, the spin direction and the sticky overflow flag. The block
// handles one request at a time. A tick, a restart or an angle sample that does
// not enter the zone near 180 degrees from an edge zone goes to the response state,
// which loads its result into the output register; the block is ready again as the
// result is loaded. An angle sample that does enter the middle zone from an edge
// zone computes a new speed as speed_base / interval_timer on a single restoring
// divider that yields one quotient bit per cycle. The sequencer waits in the divide
// state until the divider is done, takes the quotient as the new speed and then
// goes to the response state, which loads the result; no new request is accepted
// before it is loaded. A result that is still waiting in the output register
// holds the next result back until the waiting one is taken. The result sits in
// an output register, so a new request is accepted while an earlier result still
// waits to be taken. Configuration registers are written through the plain write
// port (index 0 speed_base, 1 interval_limit, 2 min_start_speed) and must only be
// written while the block is idle.
module rotor_spin_direction_speed_detect
    import rsdsd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [CFG_DW-1:0] i_cfg_wdata,
    rsdsd_in_if.sink          i_in,
    rsdsd_res_if.source       o_res
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV = 2'd1;
    localparam logic [1:0] ST_RESP = 2'd2;

    // Configuration registers.
    logic [31:0] r_speed_base;
    logic [14:0] r_ilimit;
    logic [31:0] r_min_speed;

    // Detector state.
    logic [1:0]  r_state, n_state;
    logic [1:0]  r_zone, n_zone;
    logic        r_tclr, n_tclr;
    logic [7:0]  r_shake, n_shake;
    logic [2:0]  r_step, n_step;
    logic [7:0]  r_store, n_store;
    logic [31:0] r_speed, n_speed;
    logic [1:0]  r_dir, n_dir;
    logic [15:0] r_itmr, n_itmr;
    logic [15:0] r_tout, n_tout;
    logic        r_ovf, n_ovf;

    // Output register.
    logic        r_out_valid, n_out_valid;
    logic [1:0]  r_out_dec, n_out_dec;
    logic [31:0] r_out_speed, n_out_speed;
    logic [1:0]  r_out_dir, n_out_dir;
    logic        r_out_ovf, n_out_ovf;

    logic        w_accept;
    logic        w_div_start;
    logic        w_div_done;
    logic [31:0] w_div_quo;
    logic [16:0] w_tlimit;
    logic [1:0]  w_other;
    logic        w_edge;
    logic [1:0]  w_edge_zone;
    logic [1:0]  w_decision;

    assign i_in.ready = (r_state == ST_IDLE);
    assign w_accept = i_in.valid && i_in.ready;

    // The timeout is three times the interval limit; 17 bits hold it.
    assign w_tlimit = {1'b0, r_ilimit, 1'b0} + {2'b00, r_ilimit};

    // Which edge zone the sample falls in, and the opposite edge.
    assign w_edge = (i_in.theta < THETA_LOW_LIM) || (i_in.theta > THETA_HIGH_LIM);
    assign w_edge_zone = (i_in.theta < THETA_LOW_LIM) ? ZONE_LOW : ZONE_HIGH;
    assign w_other = (w_edge_zone == ZONE_LOW) ? ZONE_HIGH : ZONE_LOW;

    rsdsd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_speed_base),
        .i_divisor  (n_itmr),
        .o_done     (w_div_done),
        .o_quotient (w_div_quo)
    );

    // Start decision, taken from the state once the request has updated it.
    always_comb begin
        if (((r_dir == DIR_CW) && (r_shake > SHAKE_LIMIT)) || r_ovf) begin
            w_decision = DEC_STANDSTILL;
        end else if ((r_dir == DIR_CCW) && (r_speed > 32'd1)
                     && (r_store >= STORE_BRAKE_MIN)) begin
            w_decision = DEC_BRAKE;
        end else if ((r_dir == DIR_CW) && (r_speed > r_min_speed)
                     && (r_store >= STORE_FWD_MIN)) begin
            w_decision = DEC_FORWARD;
        end else begin
            w_decision = DEC_NONE;
        end
    end

    always_comb begin
        n_state = r_state;
        n_zone = r_zone;
        n_tclr = r_tclr;
        n_shake = r_shake;
        n_step = r_step;
        n_store = r_store;
        n_speed = r_speed;
        n_dir = r_dir;
        n_itmr = r_itmr;
        n_tout = r_tout;
        n_ovf = r_ovf;
        n_out_valid = r_out_valid;
        n_out_dec = r_out_dec;
        n_out_speed = r_out_speed;
        n_out_dir = r_out_dir;
        n_out_ovf = r_out_ovf;
        w_div_start = 1'b0;

        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_RESP;
                    if (i_in.mode == MODE_ANGLE) begin
                        if (w_edge) begin
                            // Entry into the zone near 0 or near 360 degrees.
                            if (!r_tclr || (r_zone == w_other)) begin
                                n_itmr = 16'd0;
                                n_tclr = 1'b1;
                                if ((r_zone == w_other) && (r_shake != 8'hFF)) begin
                                    n_shake = r_shake + 8'd1;
                                end
                                if ((r_step == 3'd0) || (r_step == 3'd1)) begin
                                    n_step = r_step + 3'd1;
                                end else begin
                                    n_step = 3'd0;
                                    if (((r_step == 3'd4) || (r_step == 3'd5))
                                        && (r_store != 8'hFF)) begin
                                        n_store = r_store + 8'd1;
                                    end
                                end
                            end
                            n_zone = w_edge_zone;
                        end else if ((i_in.theta > THETA_MID_LO)
                                     && (i_in.theta < THETA_MID_HI)) begin
                            // Entry into the middle zone: a half turn is done.
                            if ((r_zone == ZONE_LOW) || (r_zone == ZONE_HIGH)) begin
                                if (r_itmr != 16'hFFFF) begin
                                    n_itmr = r_itmr + 16'd1;
                                end
                                w_div_start = 1'b1;
                                n_state = ST_DIV;
                                if ((r_step == 3'd1) || (r_step == 3'd2)) begin
                                    n_step = r_step + 3'd3;
                                end else if (r_step != 3'd0) begin
                                    n_step = 3'd0;
                                end
                                if (r_store != 8'hFF) begin
                                    n_store = r_store + 8'd1;
                                end
                                n_tclr = 1'b0;
                                n_dir = (r_zone == ZONE_LOW) ? DIR_CW : DIR_CCW;
                                n_shake = 8'd0;
                            end
                            n_zone = ZONE_MID;
                        end
                    end else if (i_in.mode == MODE_TICK) begin
                        if (r_itmr < {1'b0, r_ilimit}) begin
                            n_itmr = r_itmr + 16'd1;
                        end
                        if (({1'b0, r_tout} < w_tlimit) && (r_tout != 16'hFFFF)) begin
                            n_tout = r_tout + 16'd1;
                        end
                        if (({1'b0, n_tout} == w_tlimit) || (n_itmr == {1'b0, r_ilimit})) begin
                            n_speed = 32'd0;
                            n_itmr = 16'd0;
                            n_ovf = 1'b1;
                        end
                    end else if (i_in.mode == MODE_RESTART) begin
                        n_zone = ZONE_NONE;
                        n_tclr = 1'b0;
                        n_shake = 8'd0;
                        n_step = 3'd0;
                        n_store = 8'd0;
                        n_speed = 32'd0;
                        n_dir = DIR_UNKNOWN;
                        n_itmr = 16'd0;
                        n_tout = 16'd0;
                        n_ovf = 1'b0;
                    end
                end
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_speed = w_div_quo;
                    n_state = ST_RESP;
                end
            end
            ST_RESP: begin
                // Hand the result to the output register once it is free.
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid = 1'b1;
                    n_out_dec = w_decision;
                    n_out_speed = r_speed;
                    n_out_dir = r_dir;
                    n_out_ovf = r_ovf;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_base <= 32'd0;
            r_ilimit <= INTERVAL_LIMIT_RESET;
            r_min_speed <= 32'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_SPEED_BASE: r_speed_base <= i_cfg_wdata;
                REG_INTERVAL_LIMIT: r_ilimit <= i_cfg_wdata[14:0];
                REG_MIN_START_SPEED: r_min_speed <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_zone <= ZONE_NONE;
            r_tclr <= 1'b0;
            r_shake <= 8'd0;
            r_step <= 3'd0;
            r_store <= 8'd0;
            r_speed <= 32'd0;
            r_dir <= DIR_UNKNOWN;
            r_itmr <= 16'd0;
            r_tout <= 16'd0;
            r_ovf <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_zone <= n_zone;
            r_tclr <= n_tclr;
            r_shake <= n_shake;
            r_step <= n_step;
            r_store <= n_store;
            r_speed <= n_speed;
            r_dir <= n_dir;
            r_itmr <= n_itmr;
            r_tout <= n_tout;
            r_ovf <= n_ovf;
            r_out_valid <= n_out_valid;
        end
        r_out_dec <= n_out_dec;
        r_out_speed <= n_out_speed;
        r_out_dir <= n_out_dir;
        r_out_ovf <= n_out_ovf;
    end

    assign o_res.valid = r_out_valid;
    assign o_res.decision = r_out_dec;
    assign o_res.speed = r_out_speed;
    assign o_res.direction = r_out_dir;
    assign o_res.overflow = r_out_ovf;

    // The divider only finishes while the sequencer waits for it.
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == ST_DIV))
        else $error("divider finished outside the divide state");

    // The step counter never passes five.
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= 3'd5)
        else $error("step counter out of range");

    // An accepted request always leaves the idle state.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != ST_IDLE))
        else $error("request accepted without leaving idle");

    // A new result is loaded only when the previous one is gone or being taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RESP && r_out_valid && !o_res.ready) |=> $stable(r_out_speed))
        else $error("pending result overwritten");

endmodule
